### hdl/b2r_pkg.sv
`timescale 1ns / 1ps
package b2r_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int DIGIT_SLOTS = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;

  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int WORK_W    = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int SLOT_AW   = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
  localparam int CNT_W     = $clog2(DIGIT_SLOTS + 1);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(57);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] CHAR_Z    = CHAR_W'(90);

  typedef struct packed {
    logic load;
    logic step;
    logic rd_first;
    logic rd_next;
  } b2r_cmd_t;

  typedef struct packed {
    logic step_last;
    logic div_done;
    logic ptr_zero;
  } b2r_sts_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] above;
    above = d - DEC_DIGITS;
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(above);
  endfunction

endpackage

### hdl/b2r_in_if.sv
`timescale 1ns / 1ps
interface b2r_in_if;
  logic                            valid;
  logic                            ready;
  logic [b2r_pkg::VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### hdl/b2r_out_if.sv
`timescale 1ns / 1ps
interface b2r_out_if;
  logic                       valid;
  logic                       ready;
  logic [b2r_pkg::CHAR_W-1:0] digit_char;
  logic                       is_last;

  modport source (output valid, output digit_char, output is_last, input ready);
  modport sink (input valid, input digit_char, input is_last, output ready);
endinterface

### hdl/b2r_cfg_if.sv
`timescale 1ns / 1ps
interface b2r_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [b2r_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink (input valid, input radix, output ready);
endinterface

### hdl/b2r_ram.sv
`timescale 1ns / 1ps
module b2r_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                          wr_data_i,
  input  logic                                      rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                          rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/b2r_ctrl.sv
`timescale 1ns / 1ps
module b2r_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  b2r_pkg::b2r_sts_t sts_i,
  output b2r_pkg::b2r_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_last && sts_i.div_done) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_first = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.ptr_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/b2r_dp.sv
`timescale 1ns / 1ps
module b2r_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [b2r_pkg::RADIX_W-1:0]     cfg_radix_i,
  input  logic [b2r_pkg::VALUE_WIDTH-1:0] value_i,
  input  b2r_pkg::b2r_cmd_t               cmd_i,
  output b2r_pkg::b2r_sts_t               sts_o,
  output logic [b2r_pkg::CHAR_W-1:0]      digit_char_o,
  output logic                            is_last_o
);

  logic [b2r_pkg::RADIX_W-1:0] radix_q;
  logic [b2r_pkg::RADIX_W-1:0] base_q;
  logic [b2r_pkg::RADIX_W-1:0] base_d;
  logic [b2r_pkg::WORK_W-1:0]  work_q;
  logic [b2r_pkg::WORK_W-1:0]  work_d;
  logic [b2r_pkg::RADIX_W-1:0] rem_q;
  logic [b2r_pkg::RADIX_W-1:0] rem_d;
  logic [b2r_pkg::STEP_W-1:0]  step_q;
  logic [b2r_pkg::CNT_W-1:0]   cnt_q;
  logic [b2r_pkg::SLOT_AW-1:0] ptr_q;
  logic [b2r_pkg::CNT_W-1:0]   cnt_dec;
  logic                        step_last;
  logic                        ram_we;
  logic                        ram_re;
  logic [b2r_pkg::SLOT_AW-1:0] rd_addr;
  logic [b2r_pkg::RADIX_W-1:0] rd_digit;

  always_comb begin
    if (radix_q < b2r_pkg::RADIX_MIN) begin
      base_d = b2r_pkg::RADIX_MIN;
    end else if (radix_q > b2r_pkg::RADIX_MAX) begin
      base_d = b2r_pkg::RADIX_MAX;
    end else begin
      base_d = radix_q;
    end
  end

  // One restoring long-division step per quotient bit, DIV_BITS bits a cycle.
  always_comb begin
    logic [b2r_pkg::RADIX_W:0]   t;
    logic [b2r_pkg::WORK_W-1:0]  w;
    logic [b2r_pkg::RADIX_W-1:0] r;
    w = work_q;
    r = rem_q;
    for (int i = 0; i < b2r_pkg::DIV_BITS; i++) begin
      t = {r, w[b2r_pkg::WORK_W-1]};
      w = {w[b2r_pkg::WORK_W-2:0], 1'b0};
      if (t >= {1'b0, base_q}) begin
        t    = t - {1'b0, base_q};
        w[0] = 1'b1;
      end
      r = t[b2r_pkg::RADIX_W-1:0];
    end
    work_d = w;
    rem_d  = r;
  end

  assign step_last = (step_q == b2r_pkg::STEP_W'(b2r_pkg::DIV_STEPS - 1));
  assign cnt_dec   = cnt_q - b2r_pkg::CNT_W'(1);
  assign ram_we    = cmd_i.step && step_last;
  assign ram_re    = cmd_i.rd_first || cmd_i.rd_next;
  assign rd_addr   = cmd_i.rd_first ? cnt_dec[b2r_pkg::SLOT_AW-1:0]
                                    : (ptr_q - b2r_pkg::SLOT_AW'(1));

  assign sts_o.step_last = step_last;
  assign sts_o.div_done  = (work_d == '0) ||
                           (cnt_q == b2r_pkg::CNT_W'(b2r_pkg::DIGIT_SLOTS - 1));
  assign sts_o.ptr_zero  = (ptr_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= b2r_pkg::RADIX_RESET;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_radix_i;
      end
      if (cmd_i.load) begin
        step_q <= '0;
        cnt_q  <= '0;
      end else if (cmd_i.step) begin
        step_q <= step_last ? '0 : step_q + b2r_pkg::STEP_W'(1);
        if (step_last) begin
          cnt_q <= cnt_q + b2r_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_d;
      work_q <= b2r_pkg::WORK_W'(value_i);
      rem_q  <= '0;
    end else if (cmd_i.step) begin
      work_q <= work_d;
      rem_q  <= step_last ? '0 : rem_d;
    end
    if (ram_re) begin
      ptr_q <= rd_addr;
    end
  end

  b2r_ram #(
    .WIDTH(b2r_pkg::RADIX_W),
    .DEPTH(b2r_pkg::DIGIT_SLOTS)
  ) u_digit_store (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(cnt_q[b2r_pkg::SLOT_AW-1:0]),
    .wr_data_i(rem_d),
    .rd_en_i  (ram_re),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_digit)
  );

  assign digit_char_o = b2r_pkg::digit_to_ascii(rd_digit);
  assign is_last_o    = (ptr_q == '0);

endmodule

### hdl/binary_to_radix_digits.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake     Payload
// cfg_i    in         valid/ready   radix (6 bits)
// in_i     in         valid/ready   value (31 bits)
// out_o    out        valid/ready   digit_char (7 bits), is_last (1 bit)
//
// One item is converted at a time: it is loaded, the long-division unit finds
// each digit (eight quotient bits a cycle) and writes it to the digit store, a
// read of the digit store is started, then the digits are sent out one by one
// while the sink is ready.
// Reset clears the control state and sets radix to 10; the digit store needs
// no clearing. Output stalls hold the current digit and no new input is taken
// until the last digit has been transferred.
module binary_to_radix_digits (
  input  logic     clk_i,
  input  logic     rst_ni,
  b2r_cfg_if.sink  cfg_i,
  b2r_in_if.sink   in_i,
  b2r_out_if.source out_o
);

  b2r_pkg::b2r_cmd_t cmd;
  b2r_pkg::b2r_sts_t sts;

  assign cfg_i.ready = 1'b1;

  b2r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b2r_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_radix_i (cfg_i.radix),
    .value_i     (in_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .digit_char_o(out_o.digit_char),
    .is_last_o   (out_o.is_last)
  );

`ifndef SYNTHESIS
  a_no_input_while_output : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready
  ) else $error("input is taken while a digit is pending");

  a_idle_after_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.is_last) |=> in_i.ready
  ) else $error("block is not ready after the last digit transfer");

  a_digit_char_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.digit_char >= b2r_pkg::CHAR_ZERO &&
                      out_o.digit_char <= b2r_pkg::CHAR_NINE) ||
                     (out_o.digit_char >= b2r_pkg::CHAR_A &&
                      out_o.digit_char <= b2r_pkg::CHAR_Z))
  ) else $error("digit character out of range");
`endif

endmodule
